### rtl/odce_pkg.sv
// Shared types and constants for the OLED draw command encoder.
package odce_pkg;

  // Panel geometry
  localparam int unsigned PANEL_WIDTH  = 96;
  localparam int unsigned PANEL_HEIGHT = 64;

  // Controller opcodes and fill-mode arguments
  localparam logic [7:0] OP_COLUMN_ADDR = 8'h15;
  localparam logic [7:0] OP_ROW_ADDR    = 8'h75;
  localparam logic [7:0] OP_LINE        = 8'h21;
  localparam logic [7:0] OP_RECT        = 8'h22;
  localparam logic [7:0] OP_FILL_MODE   = 8'h26;
  localparam logic [7:0] FILL_ON        = 8'h01;
  localparam logic [7:0] FILL_OFF       = 8'h00;

  // Byte sequencer
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] LAST_IDX_SHORT = IDX_W'(7);
  localparam logic [IDX_W-1:0] LAST_IDX_RECT  = IDX_W'(12);

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request kinds, same codes as req_type
  typedef enum logic [2:0] {
    K_POINT   = 3'd0,
    K_LINE    = 3'd1,
    K_HLINE   = 3'd2,
    K_VLINE   = 3'd3,
    K_OUTLINE = 3'd4,
    K_FILLED  = 3'd5
  } req_kind_t;

  // Classified request: ends already resolved by the front
  typedef struct packed {
    req_kind_t   kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  xe;
    logic [7:0]  ye;
    logic [15:0] color;
  } draw_desc_t;

endpackage

### rtl/odce_front.sv
// Front stage: accepts requests, drops off-panel ones, resolves end points.
module odce_front import odce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type,
  input  logic [7:0]  x_start,
  input  logic [7:0]  y_start,
  input  logic [7:0]  x_end_or_width,
  input  logic [7:0]  y_end_or_height,
  input  logic [15:0] color,
  output logic        q_push,
  output draw_desc_t  q_wdata,
  input  logic        q_full
);

  logic       f_valid;
  draw_desc_t f_desc;
  draw_desc_t desc_next;
  logic       keep;
  logic       start_on;
  logic [8:0] sum_x;
  logic [8:0] sum_y;
  logic [7:0] lim_x;
  logic [7:0] lim_y;
  logic       accept;

  // Clamped ends for horizontal and vertical lines
  assign sum_x = {1'b0, x_start} + {1'b0, x_end_or_width};
  assign sum_y = {1'b0, y_start} + {1'b0, y_end_or_height};
  assign lim_x = (sum_x > 9'(PANEL_WIDTH - 1))  ? 8'(PANEL_WIDTH - 1)  : sum_x[7:0];
  assign lim_y = (sum_y > 9'(PANEL_HEIGHT - 1)) ? 8'(PANEL_HEIGHT - 1) : sum_y[7:0];

  assign start_on = (9'(x_start) < 9'(PANEL_WIDTH)) && (9'(y_start) < 9'(PANEL_HEIGHT));

  // Classify the request
  always_comb begin
    keep            = 1'b0;
    desc_next.kind  = K_POINT;
    desc_next.x     = x_start;
    desc_next.y     = y_start;
    desc_next.xe    = x_end_or_width;
    desc_next.ye    = y_end_or_height;
    desc_next.color = color;
    unique case (req_type) inside
      3'(K_POINT): begin
        keep           = start_on;
        desc_next.kind = K_POINT;
      end
      3'(K_LINE): begin
        keep = start_on && (9'(x_end_or_width) < 9'(PANEL_WIDTH))
                        && (9'(y_end_or_height) < 9'(PANEL_HEIGHT));
        desc_next.kind = K_LINE;
      end
      3'(K_HLINE): begin
        keep           = start_on;
        desc_next.kind = K_HLINE;
        desc_next.xe   = lim_x;
        desc_next.ye   = y_start;
      end
      3'(K_VLINE): begin
        keep           = start_on;
        desc_next.kind = K_VLINE;
        desc_next.xe   = x_start;
        desc_next.ye   = lim_y;
      end
      3'(K_OUTLINE), 3'(K_FILLED): begin
        keep           = start_on;
        desc_next.kind = (req_type == 3'(K_FILLED)) ? K_FILLED : K_OUTLINE;
        desc_next.xe   = x_start + x_end_or_width - 8'd1;
        desc_next.ye   = y_start + y_end_or_height - 8'd1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Front holding register feeding the queue
  assign q_push  = f_valid && !q_full;
  assign q_wdata = f_desc;
  assign full    = f_valid && q_full;
  assign accept  = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= keep;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_desc <= desc_next;
    end
  end

endmodule

### rtl/odce_queue.sv
// Short descriptor queue between the front and the byte sequencer.
module odce_queue import odce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  draw_desc_t wdata,
  output logic       full,
  input  logic       pop,
  output draw_desc_t rdata,
  output logic       empty
);

  draw_desc_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

### rtl/odce_back.sv
// Back stage: walks one descriptor byte by byte into the output register.
module odce_back import odce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  draw_desc_t q_rdata,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       last
);

  logic             cur_valid;
  draw_desc_t       cur;
  logic [IDX_W-1:0] idx;
  logic             out_valid;
  logic             slot_free;
  logic             emit;
  logic             is_rect;
  logic             is_filled;
  logic [IDX_W-1:0] last_idx;
  logic             byte_last;
  logic [7:0]       byte_val;
  logic             byte_data;
  logic [7:0]       ca0;
  logic [7:0]       ca1;
  logic [7:0]       ca2;
  logic [7:0]       cb2;

  // Color byte forms
  assign ca0 = {2'b00, cur.color[15:10]};
  assign ca1 = cur.color[12:5];
  assign ca2 = {cur.color[6:0], 1'b0};
  assign cb2 = {3'b000, cur.color[15:11]};

  assign is_rect   = (cur.kind == K_OUTLINE) || (cur.kind == K_FILLED);
  assign is_filled = (cur.kind == K_FILLED);
  assign last_idx  = is_rect ? LAST_IDX_RECT : LAST_IDX_SHORT;
  assign byte_last = (idx == last_idx);

  assign slot_free = !out_valid || pop;
  assign emit      = cur_valid && slot_free;
  assign q_pop     = (!cur_valid || (emit && byte_last)) && !q_empty;

  // Byte selection for the current position
  always_comb begin
    byte_val  = 8'h00;
    byte_data = 1'b0;
    unique case (cur.kind) inside
      K_POINT: begin
        case (idx)
          4'd0:    byte_val = OP_COLUMN_ADDR;
          4'd1:    byte_val = cur.x;
          4'd2:    byte_val = cur.x;
          4'd3:    byte_val = OP_ROW_ADDR;
          4'd4:    byte_val = cur.y;
          4'd5:    byte_val = cur.y;
          4'd6: begin
            byte_val  = cur.color[15:8];
            byte_data = 1'b1;
          end
          default: begin
            byte_val  = cur.color[7:0];
            byte_data = 1'b1;
          end
        endcase
      end
      K_LINE, K_HLINE, K_VLINE: begin
        case (idx)
          4'd0:    byte_val = OP_LINE;
          4'd1:    byte_val = cur.x;
          4'd2:    byte_val = cur.y;
          4'd3:    byte_val = cur.xe;
          4'd4:    byte_val = cur.ye;
          4'd5:    byte_val = (cur.kind == K_LINE) ? ca0 : ca2;
          4'd6:    byte_val = ca1;
          default: byte_val = (cur.kind == K_LINE) ? ca2 : cb2;
        endcase
      end
      K_OUTLINE, K_FILLED: begin
        case (idx)
          4'd0:    byte_val = OP_FILL_MODE;
          4'd1:    byte_val = is_filled ? FILL_ON : FILL_OFF;
          4'd2:    byte_val = OP_RECT;
          4'd3:    byte_val = cur.x;
          4'd4:    byte_val = cur.y;
          4'd5:    byte_val = cur.xe;
          4'd6:    byte_val = cur.ye;
          4'd7:    byte_val = ca0;
          4'd8:    byte_val = ca1;
          4'd9:    byte_val = ca2;
          4'd10:   byte_val = is_filled ? ca0 : 8'h00;
          4'd11:   byte_val = is_filled ? ca1 : 8'h00;
          default: byte_val = is_filled ? ca2 : 8'h00;
        endcase
      end
      default: begin
        byte_val  = 8'h00;
        byte_data = 1'b0;
      end
    endcase
  end

  // Current descriptor and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (emit) begin
      if (byte_last) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rdata;
    end
  end

  // Output register: next byte loads as the waiting one is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= byte_val;
      is_data  <= byte_data;
      last     <= byte_last;
    end
  end

  assign empty = !out_valid;

  // Position never runs past the end of the sequence
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (idx <= last_idx))
    else $error("byte position beyond sequence end");

  // A finished sequence restarts at the first byte
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (emit && byte_last) |=> (idx == '0))
    else $error("byte position not reset after last byte");

  // A loaded descriptor is live at its first byte
  a_load: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (cur_valid && (idx == '0)))
    else $error("descriptor load did not start a sequence");

  // Data bytes only come from point requests
  a_data_point: assert property (@(posedge clk) disable iff (rst)
    (emit && byte_data) |-> (cur.kind == K_POINT))
    else $error("data flag on a non-point sequence");

endmodule

### rtl/oled_draw_command_encoder.sv
// Top level of the OLED draw command encoder.
// Each accepted drawing request becomes its controller byte sequence, one byte
// per transfer on the result side: 8 bytes for a point or any line, 13 for a
// rectangle, with the final byte flagged by last. A request with its start off
// the panel, a line with an end off the panel, or an unknown type is accepted
// and yields no bytes. The byte sequencer issues one byte per clock while its
// output register is empty or being popped, and the bytes of consecutive
// requests follow with no gap. The input side takes one request per clock as
// long as the front register and the two-entry request queue have room; full
// rises only when both are occupied. A request passes the front register, the
// queue, the current descriptor register and the output register to be shown.
module oled_draw_command_encoder import odce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type,
  input  logic [7:0]  x_start,
  input  logic [7:0]  y_start,
  input  logic [7:0]  x_end_or_width,
  input  logic [7:0]  y_end_or_height,
  input  logic [15:0] color,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        is_data,
  output logic        last
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  draw_desc_t q_wdata;
  draw_desc_t q_rdata;

  // Request classification
  odce_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .req_type        (req_type),
    .x_start         (x_start),
    .y_start         (y_start),
    .x_end_or_width  (x_end_or_width),
    .y_end_or_height (y_end_or_height),
    .color           (color),
    .q_push          (q_push),
    .q_wdata         (q_wdata),
    .q_full          (q_full)
  );

  // Decoupling queue
  odce_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Byte sequencer
  odce_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_rdata  (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .is_data  (is_data),
    .last     (last)
  );

endmodule
